### src/fpba_pkg.sv
// ----------------------------------------------------------------------------
// Fit-policy block allocator package
// Shared widths, codes and the table entry and memory request types.
// ----------------------------------------------------------------------------
package fpba_pkg;

    localparam int ADDR_BITS  = 16;
    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int LEN_W      = ADDR_BITS + 1;
    localparam int ENT_W      = ADDR_BITS + LEN_W;

    localparam logic [LEN_W-1:0] POOL_MAX = LEN_W'(1) << ADDR_BITS;

    // Configuration register indexes.
    localparam logic CFG_FIT  = 1'b0;
    localparam logic CFG_POOL = 1'b1;

    // Placement rules.
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Request kinds.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]     len;
        logic [ADDR_BITS-1:0] start;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

### src/fit_policy_block_allocator_top.sv
// ----------------------------------------------------------------------------
// Fit-policy block allocator
// First, best or worst fit allocator over free and allocated block tables.
// ----------------------------------------------------------------------------
// Each request is handled on its own by a sequencer that walks the two block
// tables, each a 64-entry RAM with a registered read, one entry at a time.
// An allocate scans the free table to place the block, closes the gap in the
// free table and then runs the statistics pass; a free searches the allocated
// table for the address, searches the free table for neighbours, does up to
// three entry removals and then runs the statistics pass. After reset or a
// pool size write the block rebuilds the single free block in its init state.
module fit_policy_block_allocator_top
    import fpba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [16:0]      i_cfg_data,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [39:0]      i_s_axis_tdata,  // request_size, block_address, pad
    input  logic             i_s_axis_tuser,  // mode
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // status, granted_address, free_bytes, used_bytes, free_chunks,
    // allocated_chunks, largest_free, smallest_free, pad
    output logic [103:0]     o_m_axis_tdata
);

    t_mem_req w_freq, w_areq;
    t_entry   w_frdata, w_ardata;

    fpba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser),
        .i_size      (i_s_axis_tdata[16:0]),
        .i_addr      (i_s_axis_tdata[32:17]),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res_data  (o_m_axis_tdata),
        .o_freq      (w_freq),
        .i_frdata    (w_frdata),
        .o_areq      (w_areq),
        .i_ardata    (w_ardata)
    );

    // Free block table.
    fpba_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_freq.we),
        .i_waddr (w_freq.waddr),
        .i_wdata (w_freq.wdata),
        .i_raddr (w_freq.raddr),
        .o_rdata (w_frdata)
    );

    // Allocated block table.
    fpba_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_alloc_ram (
        .i_clk   (i_clk),
        .i_we    (w_areq.we),
        .i_waddr (w_areq.waddr),
        .i_wdata (w_areq.wdata),
        .i_raddr (w_areq.raddr),
        .o_rdata (w_ardata)
    );

endmodule

### src/fpba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module fpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/fpba_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Scans, compacts and appends the free and allocated tables held in RAM,
// gathers the statistics and holds the result register.
// ----------------------------------------------------------------------------
module fpba_ctrl
    import fpba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [LEN_W-1:0]     i_cfg_data,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  logic                 i_mode,
    input  logic [LEN_W-1:0]     i_size,
    input  logic [ADDR_BITS-1:0] i_addr,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic [103:0]         o_res_data,
    output t_mem_req             o_freq,
    input  t_entry               i_frdata,
    output t_mem_req             o_areq,
    input  t_entry               i_ardata
);

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_AS_RD  = 5'd2;
    localparam logic [4:0] S_AS_EV  = 5'd3;
    localparam logic [4:0] S_AS_END = 5'd4;
    localparam logic [4:0] S_A_APP  = 5'd5;
    localparam logic [4:0] S_FH_RD  = 5'd6;
    localparam logic [4:0] S_FH_EV  = 5'd7;
    localparam logic [4:0] S_FN_RD  = 5'd8;
    localparam logic [4:0] S_FN_EV  = 5'd9;
    localparam logic [4:0] S_FN_END = 5'd10;
    localparam logic [4:0] S_FD2    = 5'd11;
    localparam logic [4:0] S_F_APP  = 5'd12;
    localparam logic [4:0] S_F_FIN  = 5'd13;
    localparam logic [4:0] S_D_RD   = 5'd14;
    localparam logic [4:0] S_D_WR   = 5'd15;
    localparam logic [4:0] S_ST0    = 5'd16;
    localparam logic [4:0] S_ST_RD  = 5'd17;
    localparam logic [4:0] S_ST_EV  = 5'd18;
    localparam logic [4:0] S_DONE   = 5'd19;

    logic [4:0]           r_state, r_ret;
    logic [1:0]           r_fit;
    logic [LEN_W-1:0]     r_pool, r_avail;
    logic [CNT_W-1:0]     r_fcnt, r_acnt, r_idx, r_di;
    logic                 r_dsel, r_found, r_pre_f, r_post_f, r_ov;
    logic [LEN_W-1:0]     r_n, r_plen, r_len, r_prelen, r_postlen, r_mlen;
    logic [ADDR_BITS-1:0] r_a, r_pstart, r_base, r_prest, r_mstart, r_grant;
    logic [IDX_W-1:0]     r_pick, r_hit, r_pre, r_post;
    logic [1:0]           r_status;
    logic [LEN_W-1:0]     r_big, r_small;
    logic [103:0]         r_odata;
    logic [CNT_W-1:0]     w_di_nx;
    logic [LEN_W:0]       w_pre_end, w_blk_end;
    logic [LEN_W-1:0]     w_cfg_pool;
    logic                 w_out_free;

    assign w_di_nx    = r_di + CNT_W'(1);
    assign w_pre_end  = {1'b0, i_frdata.start} + {1'b0, i_frdata.len};
    assign w_blk_end  = {1'b0, r_base} + {1'b0, r_len};
    assign w_out_free = !r_ov || i_res_ready;
    assign w_cfg_pool = (i_cfg_data == '0) ? LEN_W'(1) :
                        (i_cfg_data > POOL_MAX) ? POOL_MAX : i_cfg_data;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_ov;
    assign o_res_data  = r_odata;

    // Free table port.
    always_comb begin
        o_freq = '0;
        o_freq.raddr = r_idx[IDX_W-1:0];
        if (r_state == S_D_RD) begin
            o_freq.raddr = w_di_nx[IDX_W-1:0];
        end
        case (r_state)
            S_INIT: begin
                o_freq.we          = 1'b1;
                o_freq.waddr       = '0;
                o_freq.wdata.start = '0;
                o_freq.wdata.len   = r_pool;
            end
            S_A_APP: begin
                o_freq.we          = (r_plen > r_n);
                o_freq.waddr       = r_fcnt[IDX_W-1:0];
                o_freq.wdata.start = r_pstart + r_n[ADDR_BITS-1:0];
                o_freq.wdata.len   = r_plen - r_n;
            end
            S_F_APP: begin
                o_freq.we          = 1'b1;
                o_freq.waddr       = r_fcnt[IDX_W-1:0];
                o_freq.wdata.start = r_mstart;
                o_freq.wdata.len   = r_mlen;
            end
            S_D_WR: begin
                o_freq.we    = !r_dsel;
                o_freq.waddr = r_di[IDX_W-1:0];
                o_freq.wdata = i_frdata;
            end
            default: ;
        endcase
    end

    // Allocated table port.
    always_comb begin
        o_areq = '0;
        o_areq.raddr = r_idx[IDX_W-1:0];
        if (r_state == S_D_RD) begin
            o_areq.raddr = w_di_nx[IDX_W-1:0];
        end
        case (r_state)
            S_A_APP: begin
                o_areq.we          = 1'b1;
                o_areq.waddr       = r_acnt[IDX_W-1:0];
                o_areq.wdata.start = r_pstart;
                o_areq.wdata.len   = r_n;
            end
            S_D_WR: begin
                o_areq.we    = r_dsel;
                o_areq.waddr = r_di[IDX_W-1:0];
                o_areq.wdata = i_ardata;
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_fit   <= FIT_FIRST;
            r_pool  <= POOL_MAX;
            r_ov    <= 1'b0;
            r_fcnt  <= '0;
            r_acnt  <= '0;
            r_avail <= '0;
        end else begin
            // The result register loads from a finished request or empties on a transfer.
            if (r_state == S_DONE && w_out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_res_ready) begin
                r_ov <= 1'b0;
            end
            // The user must write the configuration only while idle; the block itself does not enforce it.
            if (i_cfg_we && i_cfg_idx == CFG_FIT) begin
                r_fit <= i_cfg_data[1:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_POOL) begin
                r_pool  <= w_cfg_pool;
                r_state <= S_INIT;
            end else begin
                case (r_state)
                    S_INIT: begin
                        r_fcnt  <= CNT_W'(1);
                        r_acnt  <= '0;
                        r_avail <= r_pool;
                        r_state <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (i_req_valid) begin
                            r_n     <= i_size;
                            r_a     <= i_addr;
                            r_grant <= '0;
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            if (i_mode == MODE_FREE) begin
                                r_state <= S_FH_RD;
                            end else if (i_size == '0) begin
                                r_status <= ST_FULL;
                                r_state  <= S_ST0;
                            end else if (i_size > r_avail) begin
                                r_status <= ST_NOSPACE;
                                r_state  <= S_ST0;
                            end else if (r_acnt >= CNT_W'(MAX_BLOCKS)) begin
                                r_status <= ST_FULL;
                                r_state  <= S_ST0;
                            end else begin
                                r_state <= S_AS_RD;
                            end
                        end
                    end
                    // Placement scan over the free table.
                    S_AS_RD: begin
                        r_state <= (r_idx < r_fcnt) ? S_AS_EV : S_AS_END;
                    end
                    S_AS_EV: begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_AS_RD;
                        if (i_frdata.len >= r_n) begin
                            if ((r_fit == FIT_FIRST) ||
                                (r_fit == FIT_BEST && (!r_found || i_frdata.len < r_plen)) ||
                                (r_fit == FIT_WORST && (!r_found || i_frdata.len > r_plen))) begin
                                r_found  <= 1'b1;
                                r_pick   <= r_idx[IDX_W-1:0];
                                r_pstart <= i_frdata.start;
                                r_plen   <= i_frdata.len;
                            end
                            if (r_fit == FIT_FIRST) begin
                                r_state <= S_AS_END;
                            end
                        end
                    end
                    S_AS_END: begin
                        if (!r_found) begin
                            r_status <= ST_NOSPACE;
                            r_state  <= S_ST0;
                        end else begin
                            r_di    <= {1'b0, r_pick};
                            r_dsel  <= 1'b0;
                            r_ret   <= S_A_APP;
                            r_state <= S_D_RD;
                        end
                    end
                    S_A_APP: begin
                        r_fcnt   <= r_fcnt + CNT_W'(r_plen > r_n);
                        r_acnt   <= r_acnt + CNT_W'(1);
                        r_avail  <= r_avail - r_n;
                        r_grant  <= r_pstart;
                        r_status <= ST_OK;
                        r_state  <= S_ST0;
                    end
                    // Address lookup in the allocated table.
                    S_FH_RD: begin
                        if (r_idx < r_acnt) begin
                            r_state <= S_FH_EV;
                        end else begin
                            r_status <= ST_BADADDR;
                            r_state  <= S_ST0;
                        end
                    end
                    S_FH_EV: begin
                        if (i_ardata.start == r_a) begin
                            r_hit    <= r_idx[IDX_W-1:0];
                            r_base   <= i_ardata.start;
                            r_len    <= i_ardata.len;
                            r_idx    <= '0;
                            r_pre_f  <= 1'b0;
                            r_post_f <= 1'b0;
                            r_state  <= S_FN_RD;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_FH_RD;
                        end
                    end
                    // Neighbour search in the free table.
                    S_FN_RD: begin
                        r_state <= (r_idx < r_fcnt) ? S_FN_EV : S_FN_END;
                    end
                    S_FN_EV: begin
                        if (!r_pre_f && w_pre_end == {1'b0, {1'b0, r_base}}) begin
                            r_pre_f  <= 1'b1;
                            r_pre    <= r_idx[IDX_W-1:0];
                            r_prest  <= i_frdata.start;
                            r_prelen <= i_frdata.len;
                        end
                        if (!r_post_f && w_blk_end == {2'b00, i_frdata.start}) begin
                            r_post_f  <= 1'b1;
                            r_post    <= r_idx[IDX_W-1:0];
                            r_postlen <= i_frdata.len;
                        end
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_FN_RD;
                    end
                    S_FN_END: begin
                        r_mstart <= r_pre_f ? r_prest : r_base;
                        r_mlen   <= r_len + (r_pre_f ? r_prelen : '0) +
                                    (r_post_f ? r_postlen : '0);
                        r_dsel   <= 1'b0;
                        if (!r_pre_f && !r_post_f && r_fcnt >= CNT_W'(MAX_BLOCKS)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_ST0;
                        end else if (r_pre_f && r_post_f) begin
                            // Drop the later entry first so the earlier keeps its index.
                            r_di    <= {1'b0, (r_pre > r_post) ? r_pre : r_post};
                            r_ret   <= S_FD2;
                            r_state <= S_D_RD;
                        end else if (r_pre_f || r_post_f) begin
                            r_di    <= {1'b0, r_pre_f ? r_pre : r_post};
                            r_ret   <= S_F_APP;
                            r_state <= S_D_RD;
                        end else begin
                            r_state <= S_F_APP;
                        end
                    end
                    S_FD2: begin
                        r_di    <= {1'b0, (r_pre > r_post) ? r_post : r_pre};
                        r_ret   <= S_F_APP;
                        r_state <= S_D_RD;
                    end
                    S_F_APP: begin
                        r_fcnt  <= r_fcnt + CNT_W'(1);
                        r_di    <= {1'b0, r_hit};
                        r_dsel  <= 1'b1;
                        r_ret   <= S_F_FIN;
                        r_state <= S_D_RD;
                    end
                    S_F_FIN: begin
                        r_avail  <= r_avail + r_len;
                        r_status <= ST_OK;
                        r_state  <= S_ST0;
                    end
                    // Entry removal: move every later entry down by one.
                    S_D_RD: begin
                        if (w_di_nx < (r_dsel ? r_acnt : r_fcnt)) begin
                            r_state <= S_D_WR;
                        end else begin
                            if (r_dsel) begin
                                r_acnt <= r_acnt - CNT_W'(1);
                            end else begin
                                r_fcnt <= r_fcnt - CNT_W'(1);
                            end
                            r_state <= r_ret;
                        end
                    end
                    S_D_WR: begin
                        r_di    <= w_di_nx;
                        r_state <= S_D_RD;
                    end
                    // Statistics pass over the free table.
                    S_ST0: begin
                        r_idx   <= '0;
                        r_big   <= '0;
                        r_small <= '0;
                        r_state <= S_ST_RD;
                    end
                    S_ST_RD: begin
                        r_state <= (r_idx < r_fcnt) ? S_ST_EV : S_DONE;
                    end
                    S_ST_EV: begin
                        if (i_frdata.len > r_big) begin
                            r_big <= i_frdata.len;
                        end
                        if (r_idx == '0 || i_frdata.len < r_small) begin
                            r_small <= i_frdata.len;
                        end
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_ST_RD;
                    end
                    S_DONE: begin
                        if (w_out_free) begin
                            r_odata <= {4'b0000, r_small, r_big, r_acnt, r_fcnt,
                                        r_pool - r_avail, r_avail, r_grant, r_status};
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_INIT;
                endcase
            end
        end
    end

endmodule

### src/fpba_chk.sv
// ----------------------------------------------------------------------------
// Allocator port checker
// Assertions on the result stream of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fpba_chk
    import fpba_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [103:0] o_m_axis_tdata
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // A failed request grants no address.
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] != ST_OK |-> o_m_axis_tdata[17:2] == 16'd0)
        else $error("address granted on a failed request");

    // An empty free table reports no block sizes.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[58:52] == 7'd0
        |-> o_m_axis_tdata[82:66] == 17'd0 && o_m_axis_tdata[99:83] == 17'd0)
        else $error("sizes reported for an empty free table");

    // A non-empty free table has a non-zero smallest block no larger than the largest.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[58:52] != 7'd0
        |-> o_m_axis_tdata[99:83] != 17'd0 && o_m_axis_tdata[99:83] <= o_m_axis_tdata[82:66])
        else $error("smallest and largest free block disagree");

    // Table counts stay within the table depth.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[58:52] <= 7'd64 && o_m_axis_tdata[65:59] <= 7'd64)
        else $error("table count out of range");

endmodule

bind fit_policy_block_allocator_top fpba_chk u_fpba_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
